// ----- sv/trdp_pkg.sv -----
// trdp_pkg: shared constants, microcode word layout and control program
// for the trial division prime range core; no dependencies
package trdp_pkg;

  localparam int VALUE_BITS    = 24;
  localparam int CAND_BITS     = VALUE_BITS + 1;
  localparam int DIV_BITS      = (VALUE_BITS + 1) / 2 + 1;
  localparam int SQ_BITS       = 2 * DIV_BITS;
  localparam int SEG_BITS      = 8;
  localparam int MAX_SEGMENT   = 128;
  localparam int SEG_RESET     = 100;
  localparam int MOD_CNT_BITS  = $clog2(VALUE_BITS);
  localparam int PC_BITS       = 4;

  localparam logic [SEG_BITS-1:0] SegMax   = SEG_BITS'(MAX_SEGMENT);
  localparam logic [SEG_BITS-1:0] SegInit  = SEG_BITS'(SEG_RESET);
  localparam logic [DIV_BITS-1:0] DivFirst = DIV_BITS'(3);
  localparam logic [DIV_BITS-1:0] DivStep  = DIV_BITS'(2);
  localparam logic [CAND_BITS-1:0] CandTwo = CAND_BITS'(2);
  localparam logic [MOD_CNT_BITS-1:0] ModLast = MOD_CNT_BITS'(VALUE_BITS - 1);

  typedef enum logic [3:0] {
    COND_NEVER     = 4'd0,
    COND_ALWAYS    = 4'd1,
    COND_NOT_START = 4'd2,
    COND_DONE      = 4'd3,
    COND_IS_TWO    = 4'd4,
    COND_TRIV      = 4'd5,
    COND_SQ_GT     = 4'd6,
    COND_MOD_BUSY  = 4'd7,
    COND_REM_ZERO  = 4'd8
  } cond_e;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_DIV_INIT  = 3'd1,
    ACT_SQUARE    = 3'd2,
    ACT_MOD_START = 3'd3,
    ACT_DIV_STEP  = 3'd4,
    ACT_FOUND     = 3'd5,
    ACT_ADVANCE   = 3'd6,
    ACT_FINISH    = 3'd7
  } act_e;

  typedef struct packed {
    logic               idle;
    act_e               act;
    cond_e              cond;
    logic [PC_BITS-1:0] target;
  } uword_t;

  typedef struct packed {
    logic start;
    logic done;
    logic is_two;
    logic triv;
    logic sq_gt;
    logic mod_busy;
    logic rem_zero;
  } flags_t;

  localparam logic [PC_BITS-1:0] PcIdle  = PC_BITS'(0);
  localparam logic [PC_BITS-1:0] PcSq    = PC_BITS'(4);
  localparam logic [PC_BITS-1:0] PcWait  = PC_BITS'(7);
  localparam logic [PC_BITS-1:0] PcPrime = PC_BITS'(10);
  localparam logic [PC_BITS-1:0] PcNext  = PC_BITS'(11);
  localparam logic [PC_BITS-1:0] PcFin   = PC_BITS'(12);
  localparam logic [PC_BITS-1:0] PcScan  = PC_BITS'(1);

  function automatic uword_t ucode_rom(logic [PC_BITS-1:0] pc);
    uword_t w;
    w = '{idle: 1'b0, act: ACT_NONE, cond: COND_NEVER, target: PcIdle};
    case (pc)
      4'd0:  w = '{idle: 1'b1, act: ACT_NONE,      cond: COND_NOT_START, target: PcIdle};
      4'd1:  w = '{idle: 1'b0, act: ACT_NONE,      cond: COND_DONE,      target: PcFin};
      4'd2:  w = '{idle: 1'b0, act: ACT_NONE,      cond: COND_IS_TWO,    target: PcPrime};
      4'd3:  w = '{idle: 1'b0, act: ACT_DIV_INIT,  cond: COND_TRIV,      target: PcNext};
      4'd4:  w = '{idle: 1'b0, act: ACT_SQUARE,    cond: COND_NEVER,     target: PcIdle};
      4'd5:  w = '{idle: 1'b0, act: ACT_NONE,      cond: COND_SQ_GT,     target: PcPrime};
      4'd6:  w = '{idle: 1'b0, act: ACT_MOD_START, cond: COND_NEVER,     target: PcIdle};
      4'd7:  w = '{idle: 1'b0, act: ACT_NONE,      cond: COND_MOD_BUSY,  target: PcWait};
      4'd8:  w = '{idle: 1'b0, act: ACT_DIV_STEP,  cond: COND_REM_ZERO,  target: PcNext};
      4'd9:  w = '{idle: 1'b0, act: ACT_NONE,      cond: COND_ALWAYS,    target: PcSq};
      4'd10: w = '{idle: 1'b0, act: ACT_FOUND,     cond: COND_NEVER,     target: PcIdle};
      4'd11: w = '{idle: 1'b0, act: ACT_ADVANCE,   cond: COND_ALWAYS,    target: PcScan};
      4'd12: w = '{idle: 1'b0, act: ACT_FINISH,    cond: COND_ALWAYS,    target: PcIdle};
      default: w = '{idle: 1'b1, act: ACT_NONE,    cond: COND_ALWAYS,    target: PcIdle};
    endcase
    return w;
  endfunction

endpackage

// ----- sv/trdp_mod.sv -----
// trdp_mod: iterative restoring remainder unit, one quotient bit per cycle
// depends on trdp_pkg
module trdp_mod
  import trdp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [DIV_BITS-1:0]   divisor_i,
  output logic                  busy_o,
  output logic [DIV_BITS-1:0]   rem_o
);

  logic                    busy_q, busy_d;
  logic [MOD_CNT_BITS-1:0] cnt_q, cnt_d;
  logic [VALUE_BITS-1:0]   dvd_q, dvd_d;
  logic [DIV_BITS-1:0]     rem_q, rem_d;
  logic [DIV_BITS:0]       trial;

  assign trial = {rem_q, dvd_q[VALUE_BITS-1]};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[VALUE_BITS-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = DIV_BITS'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = trial[DIV_BITS-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ModLast) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

// ----- sv/trdp_seq.sv -----
// trdp_seq: step counter and control store, picks the next step from
// the current word's jump condition; depends on trdp_pkg
module trdp_seq
  import trdp_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  flags_t flags_i,
  output uword_t uword_o
);

  logic [PC_BITS-1:0] pc_q, pc_d;
  uword_t             uw;
  logic               take;

  assign uw = ucode_rom(pc_q);

  always_comb begin
    case (uw.cond)
      COND_NEVER:     take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_NOT_START: take = !flags_i.start;
      COND_DONE:      take = flags_i.done;
      COND_IS_TWO:    take = flags_i.is_two;
      COND_TRIV:      take = flags_i.triv;
      COND_SQ_GT:     take = flags_i.sq_gt;
      COND_MOD_BUSY:  take = flags_i.mod_busy;
      COND_REM_ZERO:  take = flags_i.rem_zero;
      default:        take = 1'b1;
    endcase
    pc_d = take ? uw.target : pc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PcIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign uword_o = uw;

endmodule

// ----- sv/trial_division_prime_range_core.sv -----
// trial_division_prime_range_core: scans start_value_i .. +segment length for primes
// each odd trial divisor of a candidate goes through the one-bit-a-cycle remainder unit;
// a 128-long segment near the top of the range takes the longest
// throughput: one start transfer per finished segment, busy_o high meanwhile
// reset: async active low, segment length returns to 100; no result stalls
// depends on trdp_pkg, trdp_seq, trdp_mod
module trial_division_prime_range_core
  import trdp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [SEG_BITS-1:0]   cfg_data_i,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] start_value_i,
  output logic                  busy_o,
  output logic                  result_valid_o,
  output logic [VALUE_BITS-1:0] prime_value_o,
  output logic                  found_o,
  output logic                  last_o
);

  uword_t uw;
  flags_t flags;

  logic [SEG_BITS-1:0]   seg_q;
  logic [CAND_BITS-1:0]  cand_q;
  logic [DIV_BITS-1:0]   div_q;
  logic [SQ_BITS-1:0]    sq_q;
  logic [SEG_BITS-1:0]   rem_cnt_q;
  logic                  pend_vld_q;
  logic [VALUE_BITS-1:0] pend_q;
  logic                  any_q;
  logic                  out_vld_q;
  logic                  out_vld_d;
  logic [VALUE_BITS-1:0] out_val_q;
  logic                  out_found_q;
  logic                  out_last_q;
  logic                  mod_busy;
  logic [DIV_BITS-1:0]   mod_rem;
  logic                  load;
  logic [SEG_BITS-1:0]   seg_eff;

  assign load    = uw.idle && start_i;
  assign seg_eff = (seg_q > SegMax) ? SegMax : seg_q;

  assign flags = '{
    start:    start_i,
    done:     (rem_cnt_q == '0) || cand_q[CAND_BITS-1],
    is_two:   (cand_q == CandTwo),
    triv:     (cand_q < CandTwo) || !cand_q[0],
    sq_gt:    sq_q > SQ_BITS'(cand_q),
    mod_busy: mod_busy,
    rem_zero: (mod_rem == '0)
  };

  assign out_vld_d = (uw.act == ACT_FOUND) ? pend_vld_q : (uw.act == ACT_FINISH);

  trdp_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .uword_o (uw)
  );

  trdp_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (uw.act == ACT_MOD_START),
    .dividend_i (cand_q[VALUE_BITS-1:0]),
    .divisor_i  (div_q),
    .busy_o     (mod_busy),
    .rem_o      (mod_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q       <= SegInit;
      cand_q      <= '0;
      div_q       <= '0;
      rem_cnt_q   <= '0;
      pend_vld_q  <= 1'b0;
      any_q       <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        seg_q <= cfg_data_i;
      end
      if (load) begin
        cand_q     <= {1'b0, start_value_i};
        rem_cnt_q  <= seg_eff;
        pend_vld_q <= 1'b0;
        any_q      <= 1'b0;
      end
      case (uw.act)
        ACT_DIV_INIT: div_q <= DivFirst;
        ACT_DIV_STEP: div_q <= div_q + DivStep;
        ACT_FOUND: begin
          pend_vld_q <= 1'b1;
          any_q      <= 1'b1;
        end
        ACT_ADVANCE: begin
          cand_q    <= cand_q + 1'b1;
          rem_cnt_q <= rem_cnt_q - 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (uw.act)
      ACT_SQUARE: sq_q <= div_q * div_q;
      ACT_FOUND: begin
        pend_q      <= cand_q[VALUE_BITS-1:0];
        out_val_q   <= pend_q;
        out_found_q <= 1'b1;
        out_last_q  <= 1'b0;
      end
      ACT_FINISH: begin
        out_val_q   <= any_q ? pend_q : '0;
        out_found_q <= any_q;
        out_last_q  <= 1'b1;
      end
      default: ;
    endcase
  end

  assign busy_o         = !uw.idle;
  assign result_valid_o = out_vld_q;
  assign prime_value_o  = out_val_q;
  assign found_o        = out_found_q;
  assign last_o         = out_last_q;

endmodule
